FILE: hdl/disk_image_sector_offset_assert.svh
// Assertion macros shared by the disk image sector offset block.
`ifndef DISK_IMAGE_SECTOR_OFFSET_ASSERT_SVH
`define DISK_IMAGE_SECTOR_OFFSET_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dso_pkg.sv
// Types and constants shared by the disk image sector offset block.
`default_nettype none

package dso_pkg;

  localparam int OFFSET_W   = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REQ_LOAD_TRACK  = 2'd0;
  localparam logic [1:0] REQ_LOAD_SECTOR = 2'd1;
  localparam logic [1:0] REQ_LOOKUP      = 2'd2;

  localparam logic [1:0] REG_IMAGE_FORMAT     = 2'd0;
  localparam logic [1:0] REG_FIXED_TRACK_SIZE = 2'd1;
  localparam logic [1:0] REG_TRACK_COUNT      = 2'd2;

  localparam logic [OFFSET_W-1:0] SECTOR_BASE_BYTES = 24'd128;
  localparam int                  UNIT_SHIFT        = 8;

  typedef struct packed {
    logic        image_format;
    logic [15:0] fixed_track_size;
    logic [7:0]  walk_len;
  } dso_cfg_t;

  typedef struct packed {
    logic [7:0] trk;
    logic       sd;
    logic [7:0] units;
    logic [5:0] total;
  } trk_entry_t;

  typedef struct packed {
    logic [7:0] id;
    logic [2:0] code;
  } sec_entry_t;

  typedef struct packed {
    logic load_track;
    logic load_sector;
    logic lookup_start;
    logic track_step;
    logic sector_start;
    logic sector_step;
    logic sector_hit;
    logic out_load;
  } dso_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic track_match;
    logic track_last;
    logic sector_none;
    logic sector_match;
    logic sector_last;
  } dso_sts_t;

endpackage

`default_nettype wire

FILE: hdl/dso_dp.sv
// Datapath: track and sector tables, walk counters and offset accumulator.
`default_nettype none

module dso_dp #(
  parameter int MAX_TRACKS         = 256,
  parameter int MAX_SECTORS        = 32,
  parameter int TRACK_HEADER_BYTES = 256
) (
  input  wire logic                           clk,
  input  wire dso_pkg::dso_cfg_t              cfg,
  input  wire dso_pkg::dso_cmd_t              cmd,
  output dso_pkg::dso_sts_t                   sts,
  // entry_index[7:0], slot_index[12:8], trk_num[20:13], side[21],
  // sector_tag[29:22], size_code[32:30], track_size_units[40:33],
  // sector_total[46:41], zero[47]
  input  wire logic [dso_pkg::IN_DATA_W-1:0]  in_data,
  output logic [dso_pkg::OFFSET_W-1:0]        res_offset,
  output logic                                res_track_found,
  output logic                                res_sector_found
);
  import dso_pkg::*;

  localparam int TIDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int SIDX_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int T_CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int S_CNT_W = $clog2(MAX_SECTORS + 1);
  localparam int SEC_DEPTH = MAX_TRACKS << SIDX_W;

  // Input fields
  logic [7:0] f_entry;
  logic [4:0] f_slot;
  logic [7:0] f_trk;
  logic       f_sd;
  logic [7:0] f_sid;
  logic [2:0] f_code;
  logic [7:0] f_units;
  logic [5:0] f_total;

  assign f_entry = in_data[7:0];
  assign f_slot  = in_data[12:8];
  assign f_trk   = in_data[20:13];
  assign f_sd    = in_data[21];
  assign f_sid   = in_data[29:22];
  assign f_code  = in_data[32:30];
  assign f_units = in_data[40:33];
  assign f_total = in_data[46:41];

  trk_entry_t trk_mem [MAX_TRACKS];
  sec_entry_t sec_mem [SEC_DEPTH];
  trk_entry_t trk_rd_r;
  sec_entry_t sec_rd_r;

  logic [TIDX_W-1:0]        trk_raddr;
  logic [TIDX_W+SIDX_W-1:0] sec_raddr;
  logic                     entry_ok;
  logic                     slot_ok;

  logic [T_CNT_W-1:0]  t_r, t_nxt, t_inc, limit;
  logic [S_CNT_W-1:0]  s_r, s_nxt, s_inc, n_r, n_nxt, n_clip;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [OFFSET_W-1:0] inner_r, inner_nxt;
  logic [OFFSET_W-1:0] trk_bytes;
  logic                tfound_r, tfound_nxt;
  logic                sfound_r, sfound_nxt;
  logic [7:0]          key_trk_r, key_trk_nxt;
  logic                key_sd_r, key_sd_nxt;
  logic [7:0]          key_sid_r, key_sid_nxt;
  logic [OFFSET_W-1:0] res_offset_r;
  logic                res_tfound_r;
  logic                res_sfound_r;

  assign entry_ok = {1'b0, f_entry} < 9'(MAX_TRACKS);
  assign slot_ok  = {2'b00, f_slot} < 7'(MAX_SECTORS);

  assign limit = ({1'b0, cfg.walk_len} > 9'(MAX_TRACKS)) ? T_CNT_W'(MAX_TRACKS)
                                                         : T_CNT_W'(cfg.walk_len);
  assign n_clip = ({1'b0, trk_rd_r.total} > 7'(MAX_SECTORS)) ? S_CNT_W'(MAX_SECTORS)
                                                             : S_CNT_W'(trk_rd_r.total);
  assign t_inc = t_r + T_CNT_W'(1);
  assign s_inc = s_r + S_CNT_W'(1);

  assign trk_raddr = cmd.lookup_start ? '0 : TIDX_W'(t_inc);
  assign sec_raddr = {TIDX_W'(t_r), (cmd.sector_start ? SIDX_W'(0) : SIDX_W'(s_inc))};

  assign trk_bytes = cfg.image_format ? OFFSET_W'({trk_rd_r.units, 8'h00})
                                      : OFFSET_W'(cfg.fixed_track_size);

  assign sts.limit_zero   = (cfg.walk_len == 8'd0);
  assign sts.track_match  = (trk_rd_r.trk == key_trk_r) && (trk_rd_r.sd == key_sd_r);
  assign sts.track_last   = (t_inc == limit);
  assign sts.sector_none  = (trk_rd_r.total == 6'd0);
  assign sts.sector_match = (sec_rd_r.id == key_sid_r);
  assign sts.sector_last  = (s_inc == n_r);

  // Table writes from load beats, registered reads for the walks
  always_ff @(posedge clk) begin
    if (cmd.load_track && entry_ok) begin
      trk_mem[TIDX_W'(f_entry)] <= '{trk: f_trk, sd: f_sd, units: f_units, total: f_total};
    end
    trk_rd_r <= trk_mem[trk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sector && entry_ok && slot_ok) begin
      sec_mem[{TIDX_W'(f_entry), SIDX_W'(f_slot)}] <= '{id: f_sid, code: f_code};
    end
    sec_rd_r <= sec_mem[sec_raddr];
  end

  always_comb begin
    t_nxt       = t_r;
    s_nxt       = s_r;
    n_nxt       = n_r;
    offset_nxt  = offset_r;
    inner_nxt   = inner_r;
    tfound_nxt  = tfound_r;
    sfound_nxt  = sfound_r;
    key_trk_nxt = key_trk_r;
    key_sd_nxt  = key_sd_r;
    key_sid_nxt = key_sid_r;
    if (cmd.lookup_start) begin
      t_nxt       = '0;
      offset_nxt  = '0;
      tfound_nxt  = 1'b0;
      sfound_nxt  = 1'b0;
      key_trk_nxt = f_trk;
      key_sd_nxt  = f_sd;
      key_sid_nxt = f_sid;
    end
    if (cmd.track_step) begin
      t_nxt      = t_inc;
      offset_nxt = offset_r + trk_bytes;
    end
    if (cmd.sector_start) begin
      s_nxt      = '0;
      n_nxt      = n_clip;
      inner_nxt  = OFFSET_W'(TRACK_HEADER_BYTES);
      tfound_nxt = 1'b1;
    end
    if (cmd.sector_step) begin
      s_nxt     = s_inc;
      inner_nxt = inner_r + (SECTOR_BASE_BYTES << sec_rd_r.code);
    end
    if (cmd.sector_hit) begin
      offset_nxt = offset_r + inner_r;
      sfound_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    s_r       <= s_nxt;
    n_r       <= n_nxt;
    offset_r  <= offset_nxt;
    inner_r   <= inner_nxt;
    tfound_r  <= tfound_nxt;
    sfound_r  <= sfound_nxt;
    key_trk_r <= key_trk_nxt;
    key_sd_r  <= key_sd_nxt;
    key_sid_r <= key_sid_nxt;
    if (cmd.out_load) begin
      res_offset_r <= offset_r;
      res_tfound_r <= tfound_r;
      res_sfound_r <= sfound_r;
    end
  end

  assign res_offset       = res_offset_r;
  assign res_track_found  = res_tfound_r;
  assign res_sector_found = res_sfound_r;

endmodule

`default_nettype wire

FILE: hdl/dso_ctrl.sv
// Controller: request decode, track and sector walk sequencing, output beat handshake.
`default_nettype none

module dso_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_req,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire dso_pkg::dso_sts_t sts,
  output dso_pkg::dso_cmd_t      cmd
);
  import dso_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TWALK,
    ST_SWALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_req)
            REQ_LOAD_TRACK:  cmd.load_track  = 1'b1;
            REQ_LOAD_SECTOR: cmd.load_sector = 1'b1;
            REQ_LOOKUP: begin
              cmd.lookup_start = 1'b1;
              state_nxt = sts.limit_zero ? ST_DONE : ST_TWALK;
            end
            default: ;
          endcase
        end
      end
      ST_TWALK: begin
        if (sts.track_match) begin
          cmd.sector_start = 1'b1;
          state_nxt = sts.sector_none ? ST_DONE : ST_SWALK;
        end else begin
          cmd.track_step = 1'b1;
          if (sts.track_last) state_nxt = ST_DONE;
        end
      end
      ST_SWALK: begin
        if (sts.sector_match) begin
          cmd.sector_hit = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.sector_step = 1'b1;
          if (sts.sector_last) state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/disk_image_sector_offset.sv
// Disk image sector offset unit: maps track, side and sector to a byte offset.
// Load beats write a table entry at the edge they are taken; loads run back to back.
// A lookup walks the track entries (up to 255) and then the sector entries of the matching
// track (up to 32), one per cycle, before raising out_tvalid with the result.
// Requests wait until a lookup is done; a result held by out_tready low holds the walk end.
// Reset loads the config register defaults and resets control; the tables stay unknown until loaded.
`default_nettype none
`include "disk_image_sector_offset_assert.svh"

module disk_image_sector_offset #(
  parameter int MAX_TRACKS         = 256,
  parameter int MAX_SECTORS        = 32,
  parameter int TRACK_HEADER_BYTES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // entry_index[7:0], slot_index[12:8], trk_num[20:13], side[21],
  // sector_tag[29:22], size_code[32:30], track_size_units[40:33],
  // sector_total[46:41], zero[47]
  input  wire logic [dso_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // byte_offset[23:0]
  output logic [dso_pkg::OUT_DATA_W-1:0]       out_tdata,
  // track_found[0], sector_found[1]
  output logic [1:0]                           out_tuser,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [dso_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [dso_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dso_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);
  import dso_pkg::*;

  dso_cfg_t cfg_r;
  dso_cmd_t cmd;
  dso_sts_t sts;
  logic     cfg_wr;
  logic     res_tfound;
  logic     res_sfound;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_format     <= 1'b0;
      cfg_r.fixed_track_size <= 16'd4864;
      cfg_r.walk_len         <= 8'd40;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_IMAGE_FORMAT:     cfg_r.image_format     <= cfg_pwdata[0];
        REG_FIXED_TRACK_SIZE: cfg_r.fixed_track_size <= cfg_pwdata[15:0];
        REG_TRACK_COUNT:      cfg_r.walk_len         <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_IMAGE_FORMAT:     cfg_prdata = CFG_DATA_W'(cfg_r.image_format);
      REG_FIXED_TRACK_SIZE: cfg_prdata = CFG_DATA_W'(cfg_r.fixed_track_size);
      REG_TRACK_COUNT:      cfg_prdata = CFG_DATA_W'(cfg_r.walk_len);
      default:              cfg_prdata = '0;
    endcase
  end

  dso_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dso_dp #(
    .MAX_TRACKS         (MAX_TRACKS),
    .MAX_SECTORS        (MAX_SECTORS),
    .TRACK_HEADER_BYTES (TRACK_HEADER_BYTES)
  ) u_dp (
    .clk              (clk),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_data          (in_tdata),
    .res_offset       (out_tdata),
    .res_track_found  (res_tfound),
    .res_sector_found (res_sfound)
  );

  assign out_tuser = {res_sfound, res_tfound};

  `DSO_ASSERT_NOW(a_sector_needs_track, out_tvalid, !out_tuser[1] || out_tuser[0], "sector found without track")
  `DSO_ASSERT_NEXT(a_busy_after_lookup, in_tvalid && in_tready && (in_tuser == REQ_LOOKUP), !in_tready, "input taken during lookup")
  `DSO_ASSERT_NOW(a_result_after_walk, $rose(out_tvalid), $past(cmd.out_load) && !$past(in_tready), "result beat without walk end")

endmodule

`default_nettype wire
